// ----- rtl/core/sme_pkg.sv -----
// shared types and constants for the stack machine executor
`default_nettype none

package sme_pkg;

    // stack geometry and drain limit
    localparam int STACK_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int WORD_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 2;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DRAIN_W     = $clog2(MAX_RESULTS);

    typedef logic [WORD_W-1:0] t_word;

    // instruction codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_POP  = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_SUB  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_OUT  = 3'd5,
        CMD_HALT = 3'd6
    } t_cmd;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_HALTED = 2'd1,
        STAT_UNDER  = 2'd2,
        STAT_OVER   = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic {
        S_EXEC  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    // per-cell shift control
    typedef struct packed {
        logic shift_down;
        logic shift_up;
    } t_cell_ctrl;

    // one result item
    typedef struct packed {
        t_word   value;
        logic    value_valid;
        logic    last;
        t_status status;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/sme_if.sv -----
// handshake interfaces for the instruction and result channels
`default_nettype none

interface sme_cmd_if
    import sme_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] operand;

    modport source (output valid, output command, output operand, input ready);
    modport sink   (input valid, input command, input operand, output ready);
endinterface

interface sme_res_if
    import sme_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value;
    logic                     value_valid;
    logic                     last;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output value, output value_valid, output last,
                    output status, input ready);
    modport sink   (input valid, input value, input value_valid, input last,
                    input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sme_cell.sv -----
// one stack cell: holds a word, shifts towards or away from the top
`default_nettype none

module sme_cell
    import sme_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_word      i_above,
    input  wire t_word      i_below,
    output t_word           o_value
);

    t_word r_value;

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_down) begin
            r_value <= i_above;
        end else if (i_ctrl.shift_up) begin
            r_value <= i_below;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- rtl/core/sme_alu.sv -----
// wrapping add, sub and mul of the two top stack words
`default_nettype none

module sme_alu
    import sme_pkg::*;
(
    input  wire t_cmd  i_op,
    input  wire t_word i_top,
    input  wire t_word i_sec,
    output t_word      o_result
);

    t_word w_prod;

    // low word of the product is all that wrapping multiply keeps
    assign w_prod = i_sec * i_top;

    // second minus top for sub
    always_comb begin
        case (i_op)
            CMD_ADD: o_result = i_sec + i_top;
            CMD_SUB: o_result = i_sec - i_top;
            CMD_MUL: o_result = w_prod;
            default: o_result = i_sec + i_top;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/stack_machine_executor_top.sv -----
// Stack machine executor: a row of shifting stack cells with cell 0 as the top.
// The result item is registered and shows in the cycle after the instruction is taken.
// Throughput: one instruction per cycle while in exec and the result slot is free; out pops
// up to MAX_RESULTS entries, one per cycle while the result slot is free, as only the top cell is read.
// Reset clears stack count, halt flag, sequencer and result valid;
// stack words are not cleared.
`default_nettype none

module stack_machine_executor_top
    import sme_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sme_cmd_if.sink   i_cmd,
    sme_res_if.source o_res
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DRAIN_W-1:0]  r_drain_n, n_drain_n;
    logic                r_halted, n_halted;
    logic                r_out_valid;
    t_result             r_res, n_res;
    logic                w_load;
    logic                w_slot_free;
    logic                w_acc;
    t_cmd                w_cmd;
    t_word               w_top_in;
    t_word               w_alu;
    t_word               w_cell [STACK_DEPTH];
    t_cell_ctrl          w_ctrl [STACK_DEPTH];
    logic                w_all_down;
    logic                w_all_up;
    logic                w_arith;

    assign w_cmd       = t_cmd'(i_cmd.command);
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_EXEC) && w_slot_free;
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    // row of stack cells
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            t_word w_above;
            t_word w_below;
            if (gi == 0) begin : g_head
                assign w_above = w_top_in;
            end else begin : g_body
                assign w_above = w_cell[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_tail
                assign w_below = '0;
            end else begin : g_inner
                assign w_below = w_cell[gi+1];
            end
            sme_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl[gi]),
                .i_above (w_above),
                .i_below (w_below),
                .o_value (w_cell[gi])
            );
        end
    endgenerate

    // arithmetic on the two top cells
    sme_alu u_alu (
        .i_op     (w_cmd),
        .i_top    (w_cell[0]),
        .i_sec    (w_cell[1]),
        .o_result (w_alu)
    );

    // cell control: push shifts all down, pop and out pull all up, arithmetic loads the top and pulls the rest up
    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_ctrl[i].shift_down = w_all_down || (w_arith && (i == 0));
            w_ctrl[i].shift_up   = w_all_up || (w_arith && (i != 0));
        end
    end

    // sequencer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_count     <= '0;
            r_drain_n   <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drain_n <= n_drain_n;
            r_halted  <= n_halted;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    // instruction decode, drain sequencing and result formation
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drain_n   = r_drain_n;
        n_halted    = r_halted;
        w_load      = 1'b0;
        w_all_down  = 1'b0;
        w_all_up    = 1'b0;
        w_arith     = 1'b0;
        w_top_in    = t_word'(i_cmd.operand);
        n_res.value       = '0;
        n_res.value_valid = 1'b0;
        n_res.last        = 1'b1;
        n_res.status      = STAT_OK;

        case (r_state)
            S_EXEC: begin
                if (w_acc) begin
                    w_load = 1'b1;
                    if (r_halted) begin
                        n_res.status = STAT_HALTED;
                    end else begin
                        case (w_cmd)
                            CMD_PUSH: begin
                                if (r_count == CNT_W'(STACK_DEPTH)) begin
                                    n_res.status = STAT_OVER;
                                end else begin
                                    w_all_down = 1'b1;
                                    n_count    = r_count + 1'b1;
                                end
                            end
                            CMD_POP: begin
                                if (r_count == '0) begin
                                    n_res.status = STAT_UNDER;
                                end else begin
                                    w_all_up = 1'b1;
                                    n_count  = r_count - 1'b1;
                                end
                            end
                            CMD_ADD, CMD_SUB, CMD_MUL: begin
                                if (r_count < CNT_W'(2)) begin
                                    n_res.status = STAT_UNDER;
                                end else begin
                                    w_arith  = 1'b1;
                                    w_top_in = w_alu;
                                    n_count  = r_count - 1'b1;
                                end
                            end
                            CMD_OUT: begin
                                if (r_count != '0) begin
                                    w_all_up          = 1'b1;
                                    n_count           = r_count - 1'b1;
                                    n_res.value       = w_cell[0];
                                    n_res.value_valid = 1'b1;
                                    n_res.last        = (r_count == CNT_W'(1)) ||
                                                        (MAX_RESULTS == 1);
                                    n_drain_n         = DRAIN_W'(1);
                                    if (!n_res.last) begin
                                        n_state = S_DRAIN;
                                    end
                                end
                            end
                            CMD_HALT: begin
                                n_halted     = 1'b1;
                                n_res.status = STAT_HALTED;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_DRAIN: begin
                if (w_slot_free) begin
                    w_load            = 1'b1;
                    w_all_up          = 1'b1;
                    n_count           = r_count - 1'b1;
                    n_drain_n         = r_drain_n + 1'b1;
                    n_res.value       = w_cell[0];
                    n_res.value_valid = 1'b1;
                    n_res.last        = (r_count == CNT_W'(1)) ||
                                        (r_drain_n == DRAIN_W'(MAX_RESULTS - 1));
                    if (n_res.last) begin
                        n_state = S_EXEC;
                    end
                end
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    // result channel
    assign o_res.valid       = r_out_valid;
    assign o_res.value       = r_res.value;
    assign o_res.value_valid = r_res.value_valid;
    assign o_res.last        = r_res.last;
    assign o_res.status      = r_res.status;

    // stack count stays within the row of cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped");

    // no instruction taken while draining
    a_drain_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !i_cmd.ready)
        else $error("instruction accepted during drain");

    // every popped result removes exactly one entry
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_res.value_valid) |=> (r_count + 1'b1 == $past(r_count)))
        else $error("stack count not decremented on popped item");

endmodule

`default_nettype wire
